// ----- design/vm16_pkg.sv -----
// shared types, constants and helpers for the vm16 instruction execute block
package vm16_pkg;

	localparam int MEM_WORDS   = 32768;
	localparam int STACK_DEPTH = 1024;
	localparam int MEM_AW      = $clog2(MEM_WORDS);
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

	localparam int IN_W  = 80;
	localparam int OUT_W = 32;

	// first word that names a register, first word past the register range
	localparam logic [15:0] REG_BASE = 16'h8000;
	localparam logic [15:0] REG_END  = 16'h8008;
	localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);

	typedef enum logic [4:0] {
		OP_HALT = 5'd0,  OP_SET  = 5'd1,  OP_PUSH = 5'd2,  OP_POP  = 5'd3,
		OP_EQ   = 5'd4,  OP_GT   = 5'd5,  OP_JMP  = 5'd6,  OP_JT   = 5'd7,
		OP_JF   = 5'd8,  OP_ADD  = 5'd9,  OP_MULT = 5'd10, OP_MOD  = 5'd11,
		OP_AND  = 5'd12, OP_OR   = 5'd13, OP_NOT  = 5'd14, OP_RMEM = 5'd15,
		OP_WMEM = 5'd16, OP_CALL = 5'd17, OP_RET  = 5'd18, OP_OUT  = 5'd19,
		OP_IN   = 5'd20, OP_NOOP = 5'd21, OP_LOAD = 5'd22
	} opcode_t;

	typedef enum logic [3:0] {
		ST_RUN    = 4'd0, ST_HALT  = 4'd1, ST_BADREG = 4'd2, ST_BADADDR = 4'd3,
		ST_SEMPTY = 4'd4, ST_SFULL = 4'd5, ST_EOF    = 4'd6, ST_BADOP   = 4'd7,
		ST_MODZ   = 4'd8
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RA, S_RB, S_RC, S_MEM, S_EXEC, S_DIV
	} state_t;

	typedef enum logic [1:0] {
		RD_A, RD_B, RD_C
	} rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		rd_sel_t rd_sel;
		logic    cap_a;
		logic    cap_b;
		logic    cap_c;
		logic    mem_rd;
		logic    exec;
		logic    div_step;
		logic    div_fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_full;
		logic err;
		logic need_div;
		logic div_last;
	} sts_t;

	// operand word names a register
	function automatic logic is_reg(input logic [15:0] w);
		return (w >= REG_BASE) && (w < REG_END);
	endfunction

	// operand word beyond the register range
	function automatic logic is_bad(input logic [15:0] w);
		return w >= REG_END;
	endfunction

	// value not a valid memory address
	function automatic logic out_of_mem(input logic [15:0] w);
		return {1'b0, w} >= MEM_LIMIT;
	endfunction

endpackage

// ----- design/vm16_dp.sv -----
// datapath: item registers, register file, data memory, call stack, divider, result register
module vm16_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  vm16_pkg::cmd_t           cmd,
	output vm16_pkg::sts_t           sts,
	input  logic [vm16_pkg::IN_W-1:0]  in_data,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [vm16_pkg::OUT_W-1:0] out_data
);
	import vm16_pkg::*;

	// latched instruction
	logic [4:0]  op_q;
	logic [15:0] a_q, b_q, c_q;
	logic [14:0] pc_q;
	logic [7:0]  ch_q;
	logic        eof_q;
	logic [15:0] va_q, vb_q, vc_q;

	// storage
	logic [15:0] rf_q [8];
	logic [15:0] rf_rd_q;
	logic [15:0] mem [MEM_WORDS];
	logic [15:0] mem_rd_q;
	logic [15:0] stk [STACK_DEPTH];
	logic [15:0] stk_rd_q;
	logic [STK_CW-1:0] cnt_q;

	// divider
	logic [15:0] rem_q, dvd_q;
	logic [4:0]  div_cnt_q;
	logic [15:0] rem_sh;

	// result register
	logic        ovld_q;
	logic [OUT_W-1:0] odata_q;

	// execute decisions
	status_t     st;
	logic [14:0] target;
	logic [1:0]  len;
	logic        jump;
	logic        rf_we;
	logic [15:0] rf_wd;
	logic        mem_we;
	logic [MEM_AW-1:0] mem_wa;
	logic [15:0] mem_wd;
	logic        push, pop;
	logic [15:0] push_d;
	logic        ov;
	logic [7:0]  oc;
	logic        need_div;
	logic [31:0] prod;
	logic [14:0] next_pc;
	logic [2:0]  rd_addr;
	logic [STK_CW-1:0] top;
	logic        dest_bad;

	// latch item on transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_data[4:0];
			a_q   <= in_data[20:5];
			b_q   <= in_data[36:21];
			c_q   <= in_data[52:37];
			pc_q  <= in_data[67:53];
			ch_q  <= in_data[75:68];
			eof_q <= in_data[76];
		end
		if (cmd.cap_a) va_q <= a_q[15] ? rf_rd_q : a_q;
		if (cmd.cap_b) vb_q <= b_q[15] ? rf_rd_q : b_q;
		if (cmd.cap_c) vc_q <= c_q[15] ? rf_rd_q : c_q;
	end

	// register file read port
	always_comb begin
		case (cmd.rd_sel)
			RD_A:    rd_addr = a_q[2:0];
			RD_B:    rd_addr = b_q[2:0];
			RD_C:    rd_addr = c_q[2:0];
			default: rd_addr = a_q[2:0];
		endcase
	end

	always_ff @(posedge clk) begin
		rf_rd_q <= rf_q[rd_addr];
	end

	// register file write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) rf_q[i] <= '0;
		end else if (rf_we) begin
			rf_q[a_q[2:0]] <= rf_wd;
		end
	end

	// data memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.mem_rd) mem_rd_q <= mem[vb_q[MEM_AW-1:0]];
	end

	// call stack, top entry read every cycle
	assign top = cnt_q - STK_CW'(1);

	always_ff @(posedge clk) begin
		if (push) stk[cnt_q[STK_AW-1:0]] <= push_d;
		stk_rd_q <= stk[top[STK_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= cnt_q + STK_CW'(1);
		end else if (pop) begin
			cnt_q <= top;
		end
	end

	assign prod = vb_q * vc_q;

	// execute: status, writes and next address
	always_comb begin
		st       = ST_RUN;
		target   = pc_q;
		jump     = 1'b0;
		len      = 2'd1;
		rf_we    = 1'b0;
		rf_wd    = '0;
		mem_we   = 1'b0;
		mem_wa   = va_q[MEM_AW-1:0];
		mem_wd   = vb_q;
		push     = 1'b0;
		pop      = 1'b0;
		push_d   = va_q;
		ov       = 1'b0;
		oc       = '0;
		need_div = 1'b0;
		dest_bad = !is_reg(a_q);
		case (op_q)
			OP_HALT: st = ST_HALT;
			OP_SET: begin
				len = 2'd3;
				if (dest_bad || is_bad(b_q)) st = ST_BADREG;
				else begin rf_we = 1'b1; rf_wd = vb_q; end
			end
			OP_PUSH: begin
				len = 2'd2;
				if (is_bad(a_q)) st = ST_BADREG;
				else if (cnt_q == STK_CW'(STACK_DEPTH)) st = ST_SFULL;
				else push = 1'b1;
			end
			OP_POP: begin
				len = 2'd2;
				if (dest_bad) st = ST_BADREG;
				else if (cnt_q == '0) st = ST_SEMPTY;
				else begin pop = 1'b1; rf_we = 1'b1; rf_wd = stk_rd_q; end
			end
			OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR: begin
				len = 2'd0;
				if (dest_bad || is_bad(b_q) || is_bad(c_q)) st = ST_BADREG;
				else begin
					rf_we = 1'b1;
					case (op_q)
						OP_EQ:   rf_wd = 16'(vb_q == vc_q);
						OP_GT:   rf_wd = 16'(vb_q > vc_q);
						OP_ADD:  rf_wd = {1'b0, 15'(vb_q + vc_q)};
						OP_MULT: rf_wd = {1'b0, prod[14:0]};
						OP_AND:  rf_wd = vb_q & vc_q;
						OP_OR:   rf_wd = vb_q | vc_q;
						OP_MOD: begin
							rf_we = 1'b0;
							if (vc_q == '0) st = ST_MODZ;
							else need_div = 1'b1;
						end
						default: rf_wd = '0;
					endcase
				end
			end
			OP_JMP: begin
				if (is_bad(a_q)) st = ST_BADREG;
				else if (out_of_mem(va_q)) st = ST_BADADDR;
				else begin jump = 1'b1; target = va_q[14:0]; end
			end
			OP_JT, OP_JF: begin
				len = 2'd3;
				if (is_bad(a_q) || is_bad(b_q)) st = ST_BADREG;
				else if ((op_q == OP_JT) == (va_q != '0)) begin
					if (out_of_mem(vb_q)) st = ST_BADADDR;
					else begin jump = 1'b1; target = vb_q[14:0]; end
				end
			end
			OP_NOT: begin
				len = 2'd3;
				if (dest_bad || is_bad(b_q)) st = ST_BADREG;
				else begin rf_we = 1'b1; rf_wd = {1'b0, ~vb_q[14:0]}; end
			end
			OP_RMEM: begin
				len = 2'd3;
				if (dest_bad || is_bad(b_q)) st = ST_BADREG;
				else if (out_of_mem(vb_q)) st = ST_BADADDR;
				else begin rf_we = 1'b1; rf_wd = mem_rd_q; end
			end
			OP_WMEM: begin
				len = 2'd3;
				if (is_bad(a_q) || is_bad(b_q)) st = ST_BADREG;
				else if (out_of_mem(va_q)) st = ST_BADADDR;
				else mem_we = 1'b1;
			end
			OP_CALL: begin
				if (is_bad(a_q)) st = ST_BADREG;
				else if (out_of_mem(va_q)) st = ST_BADADDR;
				else if (cnt_q == STK_CW'(STACK_DEPTH)) st = ST_SFULL;
				else begin
					push   = 1'b1;
					push_d = {1'b0, 15'(pc_q + 15'd2)};
					jump   = 1'b1;
					target = va_q[14:0];
				end
			end
			OP_RET: begin
				if (cnt_q == '0) st = ST_SEMPTY;
				else if (out_of_mem(stk_rd_q)) st = ST_BADADDR;
				else begin pop = 1'b1; jump = 1'b1; target = stk_rd_q[14:0]; end
			end
			OP_OUT: begin
				len = 2'd2;
				if (is_bad(a_q)) st = ST_BADREG;
				else begin ov = 1'b1; oc = va_q[7:0]; end
			end
			OP_IN: begin
				len = 2'd2;
				if (dest_bad) st = ST_BADREG;
				else if (eof_q) st = ST_EOF;
				else begin rf_we = 1'b1; rf_wd = {8'd0, ch_q}; end
			end
			OP_NOOP: ;
			OP_LOAD: begin
				len = 2'd3;
				if (out_of_mem(a_q)) st = ST_BADADDR;
				else begin mem_we = 1'b1; mem_wa = a_q[MEM_AW-1:0]; mem_wd = b_q; end
			end
			default: st = ST_BADOP;
		endcase
		// nothing commits outside the execute cycle, except the remainder write
		if (!cmd.exec || st != ST_RUN) begin
			rf_we = 1'b0; mem_we = 1'b0; push = 1'b0; pop = 1'b0;
		end
		if (cmd.div_fin) begin
			rf_we = 1'b1;
			rf_wd = rem_sh >= vc_q ? rem_sh - vc_q : rem_sh;
		end
		if (st != ST_RUN) begin
			ov = 1'b0; oc = '0;
		end
	end

	// four-word arithmetic ops encode length zero above; fix it here
	always_comb begin
		if (st != ST_RUN) next_pc = pc_q;
		else if (len == 2'd0) next_pc = pc_q + 15'd4;
		else next_pc = target + (jump ? 15'd0 : 15'(len));
	end

	// restoring divider, one quotient bit per cycle
	assign rem_sh = {rem_q[14:0], dvd_q[15]};

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rem_q <= '0;
			dvd_q <= vb_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_sh >= vc_q ? rem_sh - vc_q : rem_sh;
			dvd_q <= {dvd_q[14:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.exec) begin
			div_cnt_q <= 5'd16;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q - 5'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if ((cmd.exec && !need_div) || cmd.div_fin) begin
			ovld_q <= 1'b1;
		end else if (out_ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.exec && !need_div) || cmd.div_fin) begin
			odata_q <= {4'd0, st, oc, ov, next_pc};
		end
	end

	assign out_valid = ovld_q;
	assign out_data  = odata_q;

	assign sts.out_full = ovld_q;
	assign sts.err      = st != ST_RUN;
	assign sts.need_div = need_div;
	assign sts.div_last = div_cnt_q == 5'd1;

endmodule

// ----- design/vm16_ctrl.sv -----
// controller: sequences operand reads, execute and the modulo iterations
module vm16_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vm16_pkg::sts_t sts,
	output vm16_pkg::cmd_t cmd
);
	import vm16_pkg::*;

	state_t state_q, state_d;
	logic   stopped_q;
	logic   accept;

	// a waiting result only holds back the execute step, not the input
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// state register and stop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			stopped_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec && sts.err) stopped_q <= 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept && !stopped_q) state_d = S_RA;
			S_RA:   state_d = S_RB;
			S_RB:   state_d = S_RC;
			S_RC:   state_d = S_MEM;
			S_MEM:  state_d = S_EXEC;
			S_EXEC: if (!sts.out_full) state_d = sts.need_div ? S_DIV : S_IDLE;
			S_DIV:  if (sts.div_last) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_A;
		case (state_q)
			S_IDLE: cmd.load = accept && !stopped_q;
			S_RA:   cmd.rd_sel = RD_A;
			S_RB: begin cmd.cap_a = 1'b1; cmd.rd_sel = RD_B; end
			S_RC: begin cmd.cap_b = 1'b1; cmd.rd_sel = RD_C; end
			S_MEM: begin cmd.cap_c = 1'b1; cmd.mem_rd = 1'b1; end
			// execute waits while the previous result is still held
			S_EXEC: cmd.exec = !sts.out_full;
			S_DIV: begin
				cmd.div_step = !sts.div_last;
				cmd.div_fin  = sts.div_last;
			end
			default: ;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE)
		else $error("input ready outside idle");

	a_err_stops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && sts.err |=> stopped_q)
		else $error("error did not stop the block");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && !sts.div_last |=> state_q == S_DIV)
		else $error("modulo left early");

	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q && state_q == S_IDLE |=> state_q == S_IDLE)
		else $error("stopped block started an instruction");

endmodule

// ----- design/vm16_instruction_execute.sv -----
// top level of the vm16 instruction execute block
//
// Executes one instruction per input transaction and returns one result
// transaction, held in an output register until taken. The result is
// registered after three register file reads through one read port, one
// data memory read and execute; a modulo also runs the bit-serial divider.
// A new instruction is taken only once the previous one has left execute
// or the divider. The next instruction is accepted while the previous
// result still waits; its execute step stalls until that result has left the output register.
// After a halt or an error the block accepts and discards every further
// instruction without a result.
module vm16_instruction_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// op[4:0], arg_a[20:5], arg_b[36:21], arg_c[52:37], pc[67:53],
	// in_char[75:68], in_eof[76], zero fill
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_pc[14:0], out_valid[15], out_char[23:16], status[27:24], zero fill
	output logic [31:0] m_tdata
);
	import vm16_pkg::*;

	cmd_t cmd;
	sts_t sts;

	vm16_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	vm16_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata)
	);

endmodule

// ----- dv/tb_vm16_instruction_execute.sv -----
// testbench for the vm16 instruction execute block: predicted results checked in order
`timescale 1ns / 100ps

module tb_vm16_instruction_execute;
	import vm16_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [15:0] R0 = 16'h8000;

	typedef struct {
		logic [4:0]  op;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] c;
		logic [14:0] pc;
		logic [7:0]  ch;
		logic        eof;
	} instr_t;

	typedef struct {
		logic [14:0] npc;
		logic        ov;
		logic [7:0]  oc;
		status_t     st;
	} result_t;

	// machine state mirror and queue of results still owed by the block
	class vm_scoreboard;
		bit [15:0] regs [8];
		bit [15:0] mem [int];
		int        mem_addrs [$];
		bit [15:0] stk [STACK_DEPTH];
		int        depth;
		bit        stopped;
		result_t   owed [$];

		function new();
			foreach (regs[i]) regs[i] = '0;
			depth = 0;
			stopped = 0;
		endfunction

		// resolve an operand word, 0 when it is beyond the register range
		function bit operand(input bit [15:0] w, output bit [15:0] v);
			v = '0;
			if (w < 16'h8000) v = w;
			else if (w < 16'h8008) v = regs[w[2:0]];
			else return 0;
			return 1;
		endfunction

		function bit dest(input bit [15:0] w, output int r);
			r = w[2:0];
			return w >= 16'h8000 && w < 16'h8008;
		endfunction

		// execute one instruction; state is only updated when commit is set
		function void execute(input instr_t it, input bit commit, output bit has,
				output result_t rs, output bit illegal);
			bit [15:0] va, vb, vc, res;
			int r, len, nxt;
			status_t st;
			bit ov;
			bit [7:0] oc;
			has = !stopped;
			illegal = 0;
			rs = '{npc: '0, ov: 0, oc: '0, st: ST_RUN};
			if (stopped) return;
			st = ST_RUN; len = 1; nxt = it.pc; ov = 0; oc = '0; res = '0;
			va = '0; vb = '0; vc = '0; r = 0;
			case (it.op)
				OP_HALT: st = ST_HALT;
				OP_SET: begin
					len = 3;
					if (!dest(it.a, r) || !operand(it.b, vb)) st = ST_BADREG;
					else if (commit) regs[r] = vb;
				end
				OP_PUSH: begin
					len = 2;
					if (!operand(it.a, va)) st = ST_BADREG;
					else if (depth >= STACK_DEPTH) st = ST_SFULL;
					else if (commit) stk[depth++] = va;
				end
				OP_POP: begin
					len = 2;
					if (!dest(it.a, r)) st = ST_BADREG;
					else if (depth == 0) st = ST_SEMPTY;
					else if (commit) regs[r] = stk[--depth];
				end
				OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR: begin
					len = 4;
					if (!dest(it.a, r) || !operand(it.b, vb) || !operand(it.c, vc))
						st = ST_BADREG;
					else begin
						case (it.op)
							OP_EQ:   res = 16'(vb == vc);
							OP_GT:   res = 16'(vb > vc);
							OP_ADD:  res = 16'((32'(vb) + vc) % 32768);
							OP_MULT: res = 16'((32'(vb) * vc) % 32768);
							OP_MOD: begin
								if (vc == 0) st = ST_MODZ;
								else res = vb % vc;
							end
							OP_AND:  res = vb & vc;
							default: res = vb | vc;
						endcase
						if (st == ST_RUN && commit) regs[r] = res;
					end
				end
				OP_JMP: begin
					if (!operand(it.a, va)) st = ST_BADREG;
					else if (va >= MEM_WORDS) st = ST_BADADDR;
					else begin nxt = va; len = 0; end
				end
				OP_JT, OP_JF: begin
					len = 3;
					if (!operand(it.a, va) || !operand(it.b, vb)) st = ST_BADREG;
					else if ((it.op == OP_JT) == (va != 0)) begin
						if (vb >= MEM_WORDS) st = ST_BADADDR;
						else begin nxt = vb; len = 0; end
					end
				end
				OP_NOT: begin
					len = 3;
					if (!dest(it.a, r) || !operand(it.b, vb)) st = ST_BADREG;
					else if (commit) regs[r] = ~vb & 16'h7fff;
				end
				OP_RMEM: begin
					len = 3;
					if (!dest(it.a, r) || !operand(it.b, vb)) st = ST_BADREG;
					else if (vb >= MEM_WORDS) st = ST_BADADDR;
					else if (!mem.exists(vb)) illegal = 1;
					else if (commit) regs[r] = mem[vb];
				end
				OP_WMEM: begin
					len = 3;
					if (!operand(it.a, va) || !operand(it.b, vb)) st = ST_BADREG;
					else if (va >= MEM_WORDS) st = ST_BADADDR;
					else if (commit) begin
						if (!mem.exists(va)) mem_addrs.push_back(va);
						mem[va] = vb;
					end
				end
				OP_CALL: begin
					if (!operand(it.a, va)) st = ST_BADREG;
					else if (va >= MEM_WORDS) st = ST_BADADDR;
					else if (depth >= STACK_DEPTH) st = ST_SFULL;
					else begin
						if (commit) stk[depth++] = 16'((it.pc + 2) & 16'h7fff);
						nxt = va; len = 0;
					end
				end
				OP_RET: begin
					if (depth == 0) st = ST_SEMPTY;
					else if (stk[depth - 1] >= MEM_WORDS) st = ST_BADADDR;
					else begin
						nxt = stk[depth - 1]; len = 0;
						if (commit) depth--;
					end
				end
				OP_OUT: begin
					len = 2;
					if (!operand(it.a, va)) st = ST_BADREG;
					else begin ov = 1; oc = va[7:0]; end
				end
				OP_IN: begin
					len = 2;
					if (!dest(it.a, r)) st = ST_BADREG;
					else if (it.eof) st = ST_EOF;
					else if (commit) regs[r] = {8'd0, it.ch};
				end
				OP_NOOP: ;
				OP_LOAD: begin
					len = 3;
					if (it.a >= MEM_WORDS) st = ST_BADADDR;
					else if (commit) begin
						if (!mem.exists(it.a)) mem_addrs.push_back(it.a);
						mem[it.a] = it.b;
					end
				end
				default: st = ST_BADOP;
			endcase
			if (st != ST_RUN) begin
				if (commit) stopped = 1;
				nxt = it.pc; ov = 0; oc = '0;
			end else begin
				nxt = (nxt + len) & 32'h7fff;
			end
			rs = '{npc: nxt[14:0], ov: ov, oc: oc, st: st};
		endfunction

		// accepted instruction: predict and queue its result
		function void note_instr(input instr_t it);
			bit has, ill;
			result_t rs;
			execute(it, 1, has, rs, ill);
			if (has) owed.push_back(rs);
		endfunction

		// returns an empty string when the result matches the oldest one owed
		function string check_result(input logic [31:0] d);
			result_t e;
			string msg;
			if (owed.size() == 0) return $sformatf("unexpected result %h", d);
			e = owed.pop_front();
			msg = "";
			if (d[14:0] !== e.npc)
				msg = {msg, $sformatf(" next_pc %h/%h", d[14:0], e.npc)};
			if (d[15] !== e.ov) msg = {msg, $sformatf(" out_valid %b/%b", d[15], e.ov)};
			if (d[23:16] !== e.oc)
				msg = {msg, $sformatf(" out_char %h/%h", d[23:16], e.oc)};
			if (d[27:24] !== e.st)
				msg = {msg, $sformatf(" status %0d/%0d", d[27:24], e.st)};
			return msg;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	vm_scoreboard sb = new();
	int  fail_count;
	int  cycles;
	bit  quiet;
	int  stall_left;

	vm16_instruction_execute dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report(input string msg);
		fail_count++;
		$display("mismatch at cycle %0d:%s", cycles, msg);
	endtask

	// gap length: mostly none or short, sometimes long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// run-time guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result side: check every accepted transaction
	always @(posedge clk) begin
		string msg;
		if (arst_n && m_tvalid && m_tready) begin
			msg = sb.check_result(m_tdata);
			if (msg != "") report(msg);
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else begin
			m_tready = 1'b1;
			if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
		end
	end

	function automatic instr_t mk(input logic [4:0] op, input logic [15:0] a,
			input logic [15:0] b, input logic [15:0] c);
		instr_t it;
		it.op = op; it.a = a; it.b = b; it.c = c;
		it.pc = 15'($urandom);
		it.ch = 8'($urandom);
		it.eof = (op == OP_IN) ? 1'b0 : 1'($urandom);
		return it;
	endfunction

	// drive one instruction and wait for its acceptance
	task automatic send(input instr_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {3'b0, it.eof, it.ch, it.pc, it.c, it.b, it.a, it.op};
		do @(posedge clk); while (!s_tready);
		sb.note_instr(it);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return R0 + 16'($urandom_range(0, 7));
		if (r == 4) return 16'd0;
		if (r == 5) return 16'd32767;
		if (r == 6) return 16'($urandom_range(0, 63));
		return 16'($urandom_range(0, 32767));
	endfunction

	// random instruction that keeps the machine running
	function automatic instr_t pick_running();
		instr_t it;
		bit has, ill;
		result_t rs;
		for (int t = 0; t < 200; t++) begin
			it = mk(5'($urandom_range(1, 22)), pick_word(), pick_word(), pick_word());
			if ($urandom_range(0, 3) == 0) it.c = 16'($urandom);
			if (it.op == OP_LOAD) begin
				it.a = 16'($urandom_range(0, 63));
				it.b = 16'($urandom);
			end
			if (it.op == OP_RMEM && sb.mem_addrs.size() != 0 && $urandom_range(0, 1))
				it.b = 16'(sb.mem_addrs[$urandom_range(0, sb.mem_addrs.size() - 1)]);
			sb.execute(it, 0, has, rs, ill);
			if (!ill && rs.st == ST_RUN) return it;
		end
		return mk(OP_NOOP, 16'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	// the single stop of the run, chosen at random
	task automatic send_stop();
		instr_t it;
		case ($urandom_range(0, 6))
			0: send(mk(OP_HALT, 16'($urandom), 16'($urandom), 16'($urandom)));
			1: send(mk(OP_SET, 16'd5, 16'd1, 16'd0));
			2: send(mk(OP_LOAD, 16'($urandom_range(32768, 65535)), 16'd1, 16'd0));
			3: begin
				while (sb.depth > 0) send(mk(OP_POP, R0 + 1, 16'd0, 16'd0));
				send(mk(OP_POP, R0, 16'd0, 16'd0));
			end
			4: begin
				it = mk(OP_IN, R0 + 2, 16'd0, 16'd0);
				it.eof = 1'b1;
				send(it);
			end
			5: send(mk(5'($urandom_range(23, 31)), 16'd0, 16'd0, 16'd0));
			default: send(mk(OP_MOD, R0 + 3, 16'd5, 16'd0));
		endcase
	endtask

	initial begin
		fail_count = 0;
		cycles = 0;
		quiet = 0;
		stall_left = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes and every opcode but halt
		send(mk(OP_LOAD, 16'd0, 16'hffff, 16'hffff));
		send(mk(OP_LOAD, 16'd32767, 16'd1, 16'd0));
		send(mk(OP_SET, R0, 16'd32767, 16'd0));
		send(mk(OP_ADD, R0 + 1, R0, 16'd1));
		send(mk(OP_MULT, R0 + 2, R0, R0));
		send(mk(OP_MOD, R0 + 3, R0, 16'd10));
		send(mk(OP_EQ, R0 + 4, R0 + 3, 16'd7));
		send(mk(OP_GT, R0 + 5, R0, R0 + 1));
		send(mk(OP_AND, R0 + 6, R0, 16'd21845));
		send(mk(OP_OR, R0 + 7, R0 + 1, 16'd0));
		send(mk(OP_NOT, R0 + 6, 16'd0, 16'd0));
		send(mk(OP_RMEM, R0 + 1, 16'd0, 16'd0));
		send(mk(OP_WMEM, 16'd100, R0 + 1, 16'd0));
		send(mk(OP_PUSH, R0 + 1, 16'd0, 16'd0));
		send(mk(OP_POP, R0 + 2, 16'd0, 16'd0));
		send(mk(OP_CALL, 16'd32767, 16'd0, 16'd0));
		send(mk(OP_RET, 16'hffff, 16'hffff, 16'hffff));
		send(mk(OP_JMP, 16'd0, 16'd0, 16'd0));
		send(mk(OP_JT, R0, 16'd200, 16'd0));
		send(mk(OP_JF, R0, 16'd300, 16'd0));
		// a jump not taken does not check its target
		send(mk(OP_JT, 16'd0, R0 + 1, 16'd0));
		send(mk(OP_OUT, 16'd65, 16'd0, 16'd0));
		send(mk(OP_OUT, R0 + 1, 16'd0, 16'd0));
		send(mk(OP_IN, R0 + 3, 16'd0, 16'd0));
		send(mk(OP_NOOP, 16'hffff, 16'hffff, 16'hffff));

		// random running instructions, quiet stretches in every other hundred
		for (int i = 0; i < 420; i++) begin
			if (i % 100 == 0) quiet = (i % 200 == 100);
			if (i == 210 || $urandom_range(0, 99) == 0) drain();
			send(pick_running());
		end
		quiet = 0;

		// one stop, then items the block must swallow
		send_stop();
		for (int i = 0; i < 6; i++) send(mk(5'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom)));
		drain();
		repeat (80) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
